>>> hw/rtl/stereo_multiband_peaking_eq_macros.svh
// ----------------------------------------------------------------------------
// stereo_multiband_peaking_eq assertion macros
// Concurrent checks sampled on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef STEREO_MULTIBAND_PEAKING_EQ_MACROS_SVH
`define STEREO_MULTIBAND_PEAKING_EQ_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SMPEQ_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SMPEQ_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/smpeq_pkg.sv
// ----------------------------------------------------------------------------
// smpeq_pkg
// Types, codes and fixed-point helpers of the stereo peaking equalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package smpeq_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COEF_W   = 24;
   localparam int DELAY_W  = 48;
   localparam int WIDE_W   = 50;
   localparam int SUM_W    = 32;
   localparam int NCOEF    = 5;

   localparam logic signed [COEF_W-1:0] UNITY_Q20 = 24'sh100000;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_WRITE  = 2'd1,
      OP_COMMIT = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // coefficient order in a bank
   localparam logic [2:0] K_B0 = 3'd0;
   localparam logic [2:0] K_B1 = 3'd1;
   localparam logic [2:0] K_B2 = 3'd2;
   localparam logic [2:0] K_A1 = 3'd3;
   localparam logic [2:0] K_A2 = 3'd4;

   // sequencer phases of one band that do more than issue a read
   localparam logic [2:0] PH_Y  = 3'd2;
   localparam logic [2:0] PH_T1 = 3'd3;
   localparam logic [2:0] PH_T2 = 3'd4;
   localparam logic [2:0] PH_Z1 = 3'd5;
   localparam logic [2:0] PH_Z2 = 3'd6;

   function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [WIDE_W-1:0] v);
      logic signed [DELAY_W-1:0] r;
      if (v[WIDE_W-1:DELAY_W-1] == '0 || v[WIDE_W-1:DELAY_W-1] == '1) begin
         r = v[DELAY_W-1:0];
      end else if (v[WIDE_W-1]) begin
         r = {1'b1, {(DELAY_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DELAY_W-1){1'b1}}};
      end
      return r;
   endfunction

   // round a 2^-43 value to Q1.23 (add half, floor shift by 20), then saturate
   function automatic logic signed [SAMPLE_W-1:0] to_q23(input logic signed [DELAY_W-1:0] acc);
      logic signed [DELAY_W:0]   r;
      logic signed [DELAY_W-20:0] q;
      logic signed [SAMPLE_W-1:0] s;
      r = {acc[DELAY_W-1], acc} + 49'sd524288;
      q = r[DELAY_W:20];
      if (q[DELAY_W-20:SAMPLE_W-1] == '0 || q[DELAY_W-20:SAMPLE_W-1] == '1) begin
         s = q[SAMPLE_W-1:0];
      end else if (q[DELAY_W-20]) begin
         s = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         s = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return s;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SUM_W-1:0] v);
      logic signed [SAMPLE_W-1:0] s;
      if (v[SUM_W-1:SAMPLE_W-1] == '0 || v[SUM_W-1:SAMPLE_W-1] == '1) begin
         s = v[SAMPLE_W-1:0];
      end else if (v[SUM_W-1]) begin
         s = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         s = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/stereo_multiband_peaking_eq.sv
// ----------------------------------------------------------------------------
// stereo_multiband_peaking_eq
// Request stream in (req_*), result stream out (rsp_*). req_tuser carries the
// opcode: sample, shadow coefficient write, bank commit, clear filter state.
// A filtered sample (channel below FILTERED_CHANNELS) runs every band through
// one shared 24x24 multiplier, one band after another. Its result is loaded
// into the output register once the last band is done and the register is
// free, and no new request is taken before that load. A pass-through sample
// returns in the next cycle; control requests finish in their accept cycle and
// return nothing. The output register holds its result while rsp_tready is
// low; a new filtered sample may be accepted meanwhile, a pass-through sample
// waits until the register frees. Synchronous reset clears delays, banks and
// handshake state; coefficients read as b0 unity, others zero, until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stereo_multiband_peaking_eq_macros.svh"

module stereo_multiband_peaking_eq
   import smpeq_pkg::*;
#(
   parameter int BANDS             = 10,
   parameter int FILTERED_CHANNELS = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // channel[2:0], sample_in[26:3], band[30:27], coeff_select[33:31],
   // coeff_value[57:34], zero[63:58]
   input  wire logic [63:0] req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // sample_out[23:0], channel_out[26:24], zero[31:27]
   output logic [31:0]      rsp_tdata
);

   localparam int BCW    = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int ZDEPTH = FILTERED_CHANNELS * BANDS;
   localparam int ZW     = (ZDEPTH > 1) ? $clog2(ZDEPTH) : 1;
   localparam int CDEPTH = BANDS * 2 * NCOEF;
   localparam int CAW    = $clog2(CDEPTH);

   // request fields
   op_type                     req_op;
   logic [2:0]                 req_channel;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic [3:0]                 req_band;
   logic [2:0]                 req_sel;
   logic signed [COEF_W-1:0]   req_cvalue;

   assign req_op      = op_type'(req_tuser);
   assign req_channel = req_tdata[2:0];
   assign req_sample  = req_tdata[26:3];
   assign req_band    = req_tdata[30:27];
   assign req_sel     = req_tdata[33:31];
   assign req_cvalue  = req_tdata[57:34];

   // control state
   state_type        state_ff, state_in;
   logic [2:0]       phase_ff, phase_in;
   logic [BCW-1:0]   band_ff, band_in;
   logic [BANDS-1:0] active_ff;
   logic             rsp_valid_ff;

   // sample datapath
   logic signed [SAMPLE_W-1:0] x_ff;
   logic [2:0]                 ch_ff;
   logic                       side_ff;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SAMPLE_W-1:0] y_ff;
   logic signed [WIDE_W-1:0]   t1_ff;
   logic signed [DELAY_W-1:0]  t2_ff;
   logic signed [DELAY_W-1:0]  prod_ff;
   logic [31:0]                rsp_data_ff;

   // filter state and coefficient store
   logic signed [DELAY_W-1:0] z1_ff [ZDEPTH];
   logic signed [DELAY_W-1:0] z2_ff [ZDEPTH];
   logic signed [COEF_W-1:0]  coef_mem [CDEPTH];
   logic [CDEPTH-1:0]         coef_vld_ff;
   logic signed [COEF_W-1:0]  coef_q_ff;
   logic                      coef_vld_q_ff;
   logic                      coef_b0_q_ff;

   logic        accept, out_free, pass_req, band_ok, start, finish, load_done;
   logic        coef_wr;
   logic [2:0]  rd_k;
   logic [CAW-1:0] rd_addr, wr_addr;
   logic [ZW-1:0]  zidx;
   logic signed [COEF_W-1:0]   coef;
   logic signed [SAMPLE_W-1:0] mul_b;
   logic signed [DELAY_W-1:0]  prod_in;
   logic signed [WIDE_W-1:0]   acc_wide;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pass_req  = (req_op == OP_SAMPLE) && (int'(req_channel) >= FILTERED_CHANNELS);
   assign req_tready = (state_ff == ST_IDLE) && (out_free || !pass_req);
   assign accept    = req_tvalid && req_tready;
   assign band_ok   = int'(req_band) < BANDS;
   assign coef_wr   = accept && (req_op == OP_WRITE) && band_ok && (int'(req_sel) < NCOEF);

   // sequencer: next state, phase and band
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      band_in   = band_ff;
      start     = 1'b0;
      finish    = 1'b0;
      load_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_SAMPLE && !pass_req) begin
               start    = 1'b1;
               state_in = ST_RUN;
               phase_in = '0;
               band_in  = '0;
            end
         end
         ST_RUN: begin
            if (phase_ff == PH_Z2) begin
               phase_in = '0;
               if (band_ff == BCW'(BANDS - 1)) begin
                  finish   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  band_in = band_ff + 1'b1;
               end
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         band_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         band_ff  <= band_in;
      end
   end

   // coefficient read address: one coefficient of the current band per phase
   assign rd_k    = (phase_ff <= K_A2) ? phase_ff : K_B0;
   assign rd_addr = CAW'({band_ff, active_ff[band_ff]} * NCOEF + rd_k);
   assign wr_addr = CAW'({req_band[BCW-1:0], !active_ff[req_band[BCW-1:0]]} * NCOEF
                         + req_sel);

   always_ff @(posedge clock) begin
      if (coef_wr) begin
         coef_mem[wr_addr] <= req_cvalue;
      end
      coef_q_ff     <= coef_mem[rd_addr];
      coef_vld_q_ff <= coef_vld_ff[rd_addr];
      coef_b0_q_ff  <= (rd_k == K_B0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
         active_ff   <= '0;
      end else begin
         if (coef_wr) begin
            coef_vld_ff[wr_addr] <= 1'b1;
         end
         if (accept && req_op == OP_COMMIT && band_ok) begin
            active_ff[req_band[BCW-1:0]] <= !active_ff[req_band[BCW-1:0]];
         end
      end
   end

   // unwritten entries read as their reset value
   assign coef = coef_vld_q_ff ? coef_q_ff : (coef_b0_q_ff ? UNITY_Q20 : '0);

   // shared multiplier: x for the feedforward taps, y for the feedback taps
   assign mul_b   = (phase_ff >= PH_T2) ? y_ff : x_ff;
   assign prod_in = coef * mul_b;

   assign zidx     = ZW'(side_ff * BANDS + band_ff);
   assign acc_wide = WIDE_W'(prod_ff) + WIDE_W'(z1_ff[zidx]);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (start) begin
         x_ff    <= req_sample;
         ch_ff   <= req_channel;
         side_ff <= (req_channel != 3'd0);
         sum_ff  <= SUM_W'(req_sample);
      end
      if (state_ff == ST_RUN) begin
         case (phase_ff)
            PH_Y:  y_ff  <= to_q23(sat48(acc_wide));
            PH_T1: t1_ff <= WIDE_W'(prod_ff) + WIDE_W'(z2_ff[zidx]);
            PH_T2: begin
               t2_ff  <= prod_ff;
               sum_ff <= sum_ff + SUM_W'(y_ff) - SUM_W'(x_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ZDEPTH; i++) begin
            z1_ff[i] <= '0;
            z2_ff[i] <= '0;
         end
      end else if (accept && req_op == OP_CLEAR) begin
         for (int i = 0; i < ZDEPTH; i++) begin
            z1_ff[i] <= '0;
            z2_ff[i] <= '0;
         end
      end else if (state_ff == ST_RUN) begin
         if (phase_ff == PH_Z1) begin
            z1_ff[zidx] <= sat48(t1_ff - WIDE_W'(prod_ff));
         end
         if (phase_ff == PH_Z2) begin
            z2_ff[zidx] <= sat48(WIDE_W'(t2_ff) - WIDE_W'(prod_ff));
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((accept && pass_req) || load_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pass_req) begin
         rsp_data_ff <= {5'd0, req_channel, req_sample};
      end else if (load_done) begin
         rsp_data_ff <= {5'd0, ch_ff, sat24(sum_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SMPEQ_ASSERT_NOW(a_phase_range, state_ff == ST_RUN, phase_ff <= PH_Z2, "phase overrun")
   `SMPEQ_ASSERT_NOW(a_band_range, state_ff == ST_RUN, int'(band_ff) < BANDS, "band overrun")
   `SMPEQ_ASSERT_NEXT(a_start_run, start, state_ff == ST_RUN && phase_ff == 3'd0, "no run")
   `SMPEQ_ASSERT_NEXT(a_done_load, finish, state_ff == ST_DONE && !req_tready, "no done")
   `SMPEQ_ASSERT_NEXT(a_done_out, load_done, rsp_valid_ff && state_ff == ST_IDLE, "no result")

endmodule

`default_nettype wire

>>> tb/sv/stereo_multiband_peaking_eq_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_multiband_peaking_eq_tb
// Self-checking bench for the stereo peaking equalizer. Requests go in on the
// req_ stream, equalized samples come back on the rsp_ stream. A fixed-point
// copy of the biquad banks, shadow/active coefficient banks and delay state
// predicts every returned sample; results are compared field by field in
// order. Both streams idle at random, with a long output hold-off, a drain
// pause and a back-to-back stretch.
// ----------------------------------------------------------------------------

module stereo_multiband_peaking_eq_tb;
   import smpeq_pkg::*;

   localparam int BANDS             = 10;
   localparam int FILTERED_CHANNELS = 2;
   localparam int DRAIN_CYCLES      = 7 * BANDS + 10;
   localparam int STALL_LIMIT       = 5000;
   localparam int HOLD_OFF_CYCLES   = 300;

   localparam longint SAT48_HI   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SAT48_LO   = -SAT48_HI - 1;
   localparam longint SAT24_HI   = 64'sd8388607;
   localparam longint SAT24_LO   = -64'sd8388608;
   localparam longint ROUND_HALF = 64'sd524288;

   localparam logic signed [23:0] PCM_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] PCM_MIN = 24'sh800000;

   typedef struct {
      op_type             op;
      logic [2:0]         channel;
      logic signed [23:0] sample;
      logic [3:0]         band;
      logic [2:0]         sel;
      logic signed [23:0] coef;
   } eq_req_type;

   typedef struct {
      logic signed [23:0] sample;
      logic [2:0]         channel;
   } eq_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // channel[2:0], sample_in[26:3], band[30:27], coeff_select[33:31],
   // coeff_value[57:34], zero[63:58]
   logic [63:0] req_tdata = '0;
   // opcode[1:0]
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // sample_out[23:0], channel_out[26:24], zero[31:27]
   logic [31:0] rsp_tdata;

   // equalizer state as seen from outside
   longint  z1_state[2][BANDS];
   longint  z2_state[2][BANDS];
   longint  coef_bank[BANDS][2][NCOEF];
   bit      active_bank[BANDS];

   eq_out_type expected_outputs[$];
   int      mismatch_count  = 0;
   int      sent_count      = 0;
   int      rsp_hold_cycles = 0;
   bit      idle_off        = 1'b0;

   stereo_multiband_peaking_eq #(
      .BANDS(BANDS),
      .FILTERED_CHANNELS(FILTERED_CHANNELS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic void clear_delays();
      for (int s = 0; s < 2; s++) begin
         for (int b = 0; b < BANDS; b++) begin
            z1_state[s][b] = 0;
            z2_state[s][b] = 0;
         end
      end
   endfunction

   // update the state for one accepted request and queue its output, if any
   function automatic void equalize_request(input eq_req_type r);
      longint     x, acc, y, c0, c1, c2, c3, c4, total;
      int         side;
      eq_out_type res;
      case (r.op)
         OP_WRITE: begin
            if (r.band < BANDS && r.sel < NCOEF)
               coef_bank[r.band][1'b1 ^ active_bank[r.band]][r.sel] = longint'(r.coef);
         end
         OP_COMMIT: begin
            if (r.band < BANDS)
               active_bank[r.band] = active_bank[r.band] ^ 1'b1;
         end
         OP_CLEAR: begin
            clear_delays();
         end
         default: begin
            x = longint'(r.sample);
            total = x;
            if (r.channel < FILTERED_CHANNELS) begin
               side = (r.channel == 3'd0) ? 0 : 1;
               for (int b = 0; b < BANDS; b++) begin
                  c0 = coef_bank[b][active_bank[b]][K_B0];
                  c1 = coef_bank[b][active_bank[b]][K_B1];
                  c2 = coef_bank[b][active_bank[b]][K_B2];
                  c3 = coef_bank[b][active_bank[b]][K_A1];
                  c4 = coef_bank[b][active_bank[b]][K_A2];
                  acc = clamp_to(c0 * x + z1_state[side][b], SAT48_LO, SAT48_HI);
                  y = clamp_to((acc + ROUND_HALF) >>> 20, SAT24_LO, SAT24_HI);
                  z1_state[side][b] = clamp_to(c1 * x - c3 * y + z2_state[side][b],
                                               SAT48_LO, SAT48_HI);
                  z2_state[side][b] = clamp_to(c2 * x - c4 * y, SAT48_LO, SAT48_HI);
                  total += y - x;
               end
               total = clamp_to(total, SAT24_LO, SAT24_HI);
            end
            res.sample  = total[23:0];
            res.channel = r.channel;
            expected_outputs.push_back(res);
         end
      endcase
   endfunction

   function automatic eq_req_type make_request(input op_type op, input logic [2:0] ch,
                                               input logic signed [23:0] x,
                                               input logic [3:0] band, input logic [2:0] sel,
                                               input logic signed [23:0] cv);
      eq_req_type r;
      r.op      = op;
      r.channel = ch;
      r.sample  = x;
      r.band    = band;
      r.sel     = sel;
      r.coef    = cv;
      return r;
   endfunction

   function automatic eq_req_type random_request(input op_type op);
      return make_request(op, 3'($urandom), 24'($urandom), 4'($urandom), 3'($urandom),
                          24'($urandom));
   endfunction

   function automatic eq_req_type random_sample();
      eq_req_type r;
      r = random_request(OP_SAMPLE);
      if ($urandom_range(0, 99) < 85)
         r.channel = 3'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: r.sample = $urandom_range(0, 1) ? PCM_MAX : PCM_MIN;
         1, 2, 3, 4: r.sample = r.sample >>> 3;
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // offer one request and hold it until the block takes it
   task automatic send_request(input eq_req_type r);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {6'b0, r.coef, r.sel, r.band, r.sample, r.channel};
      do @(posedge clock); while (!req_tready);
      equalize_request(r);
      sent_count++;
   endtask

   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_outputs.size() != 0);
   endtask

   // load a shadow bank with mostly stable coefficients, then usually commit it
   task automatic program_band(input int band_idx);
      int         coefs[NCOEF];
      int         lim;
      eq_req_type r;
      coefs[K_B0] = (1 << 20) + int'($urandom_range(0, 1 << 20)) - (1 << 19);
      coefs[K_B1] = int'($urandom_range(0, 1 << 22)) - (1 << 21);
      coefs[K_B2] = int'($urandom_range(0, 1 << 20)) - (1 << 19);
      coefs[K_A2] = int'($urandom_range(0, 1400000)) - (1 << 19);
      lim = ((1 << 20) + coefs[K_A2]) * 9 / 10;
      coefs[K_A1] = int'($urandom_range(0, 2 * lim)) - lim;
      for (int k = 0; k < NCOEF; k++) begin
         r = random_request(OP_WRITE);
         r.band = 4'(band_idx);
         r.sel  = 3'(k);
         if ($urandom_range(0, 19) != 0)
            r.coef = 24'(coefs[k]);
         send_request(r);
      end
      if ($urandom_range(0, 9) != 0) begin
         r = random_request(OP_COMMIT);
         r.band = 4'(band_idx);
         send_request(r);
      end
   endtask

   task automatic test_reset_passthrough();
      send_request(make_request(OP_SAMPLE, 3'd0, PCM_MAX, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd1, PCM_MIN, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd0, 24'sd0, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd1, -24'sd1, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd2, 24'sd1234, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd7, PCM_MIN, 4'd15, 3'd7, PCM_MAX));
   endtask

   task automatic test_bank_control();
      // shadow write stays invisible until the commit
      send_request(make_request(OP_WRITE, 3'd0, 24'sd0, 4'd0, K_B0, PCM_MAX));
      send_request(make_request(OP_SAMPLE, 3'd0, 24'sh400000, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_COMMIT, 3'd0, 24'sd0, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_WRITE, 3'd0, 24'sd0, 4'd1, K_B0, PCM_MAX));
      send_request(make_request(OP_COMMIT, 3'd0, 24'sd0, 4'd1, 3'd0, 24'sd0));
      // two boosted bands drive the sum past the upper rail and onto the lower one
      send_request(make_request(OP_SAMPLE, 3'd0, 24'sh400000, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd1, PCM_MIN, 4'd0, 3'd0, 24'sd0));
      // out-of-range band and select are dropped
      send_request(make_request(OP_WRITE, 3'd0, 24'sd0, 4'd15, K_B0, 24'sd0));
      send_request(make_request(OP_WRITE, 3'd0, 24'sd0, 4'd2, 3'd6, PCM_MIN));
      send_request(make_request(OP_WRITE, 3'd0, 24'sd0, 4'd3, 3'd7, PCM_MIN));
      send_request(make_request(OP_COMMIT, 3'd0, 24'sd0, 4'd12, 3'd0, 24'sd0));
      // strong feedback on band 9
      send_request(make_request(OP_WRITE, 3'd0, 24'sd0, 4'd9, K_A1, PCM_MIN));
      send_request(make_request(OP_WRITE, 3'd0, 24'sd0, 4'd9, K_A2, 24'sh0C0000));
      send_request(make_request(OP_COMMIT, 3'd0, 24'sd0, 4'd9, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd0, 24'sd1000, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd0, -24'sd1000, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd1, PCM_MAX, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd2, PCM_MAX, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_CLEAR, 3'd0, 24'sd0, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_SAMPLE, 3'd0, 24'sd1000, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_COMMIT, 3'd0, 24'sd0, 4'd0, 3'd0, 24'sd0));
      send_request(make_request(OP_COMMIT, 3'd0, 24'sd0, 4'd1, 3'd0, 24'sd0));
   endtask

   task automatic test_random_traffic(input int item_total);
      int stop_at;
      int pick;
      stop_at = sent_count + item_total;
      while (sent_count < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            repeat ($urandom_range(1, 12)) send_request(random_sample());
         end else if (pick < 85) begin
            program_band($urandom_range(0, BANDS - 1));
         end else if (pick < 95) begin
            send_request(random_request(op_type'($urandom_range(1, 2))));
         end else if (pick < 98) begin
            send_request(random_request(OP_CLEAR));
         end else begin
            drain_outputs();
         end
      end
   endtask

   // receiver holds off while the sender keeps offering samples
   task automatic test_output_backpressure();
      rsp_hold_cycles = HOLD_OFF_CYCLES;
      repeat (16) send_request(random_sample());
   endtask

   task automatic test_sender_pause();
      repeat (6) send_request(random_sample());
      drain_outputs();
      repeat (6) send_request(random_sample());
   endtask

   task automatic test_back_to_back();
      idle_off = 1'b1;
      test_random_traffic(150);
      idle_off = 1'b0;
   endtask

   initial begin : rsp_side
      int         stall;
      eq_out_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_hold_cycles + (idle_off ? 0 : $urandom_range(0, 4));
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (expected_outputs.size() == 0) begin
            report_failure($sformatf("unexpected result: sample %0d channel %0d",
                                     $signed(rsp_tdata[23:0]), rsp_tdata[26:24]));
         end else begin
            want = expected_outputs.pop_front();
            if (rsp_tdata[23:0] !== want.sample)
               report_failure($sformatf("sample_out: expected %0d, got %0d",
                                        want.sample, $signed(rsp_tdata[23:0])));
            if (rsp_tdata[26:24] !== want.channel)
               report_failure($sformatf("channel_out: expected %0d, got %0d",
                                        want.channel, rsp_tdata[26:24]));
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      clear_delays();
      for (int b = 0; b < BANDS; b++) begin
         active_bank[b] = 1'b0;
         for (int k = 0; k < 2 * NCOEF; k++)
            coef_bank[b][k / NCOEF][k % NCOEF] = (k % NCOEF == 0) ? longint'(UNITY_Q20) : 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_bank_control();
      test_random_traffic(600);
      test_output_backpressure();
      test_sender_pause();
      test_back_to_back();
      test_random_traffic(550);

      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_outputs.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
